### rtl/lpi_pkg.sv
// lpi_pkg: shared widths, controller states and command/status types
// for the linear point interpolator; no dependencies
`default_nettype none

package lpi_pkg;

  localparam int COORD_BITS = 16;
  localparam int TIME_BITS  = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = COORD_BITS + TIME_BITS;
  localparam int BASE_BITS  = COORD_BITS + 2;
  localparam int DIV_STEPS  = PROD_BITS;
  localparam int CNT_BITS   = $clog2(DIV_STEPS);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } lpi_state_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic mul;
    logic step;
    logic finish;
  } lpi_cmd_t;

  typedef struct packed {
    logic out_free;
  } lpi_stat_t;

endpackage

`default_nettype wire

### rtl/lpi_ctrl.sv
// lpi_ctrl: sequencer for one request: load, difference, multiply,
// bit-serial divide, round and hand off; uses lpi_pkg
`default_nettype none

module lpi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lpi_pkg::lpi_stat_t stat,
  output lpi_pkg::lpi_cmd_t      cmd
);

  lpi_pkg::lpi_state_t state_r, state_nxt;
  logic [lpi_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic last_step;

  assign last_step = (cnt_r == lpi_pkg::CNT_BITS'(lpi_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpi_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      lpi_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lpi_pkg::ST_PREP;
      end
      lpi_pkg::ST_PREP: state_nxt = lpi_pkg::ST_MUL;
      lpi_pkg::ST_MUL: begin
        state_nxt = lpi_pkg::ST_DIV;
        cnt_nxt   = '0;
      end
      lpi_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) state_nxt = lpi_pkg::ST_DONE;
      end
      lpi_pkg::ST_DONE: begin
        if (stat.out_free) state_nxt = lpi_pkg::ST_IDLE;
      end
      default: state_nxt = lpi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      lpi_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      lpi_pkg::ST_PREP: cmd.prep   = 1'b1;
      lpi_pkg::ST_MUL:  cmd.mul    = 1'b1;
      lpi_pkg::ST_DIV:  cmd.step   = 1'b1;
      lpi_pkg::ST_DONE: cmd.finish = stat.out_free;
      default: cmd = '0;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.prep, cmd.mul, cmd.step, cmd.finish}))
    else $error("more than one command");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpi_pkg::ST_DIV && !last_step) |=> state_r == lpi_pkg::ST_DIV)
    else $error("divide cut short");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> in_stall)
    else $error("accepted while busy");

endmodule

`default_nettype wire

### rtl/lpi_dp.sv
// lpi_dp: motion state, difference and multiply, two restoring dividers,
// rounding and output register; uses lpi_pkg, driven by lpi_ctrl
`default_nettype none

module lpi_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire lpi_pkg::lpi_cmd_t                     cmd,
  output lpi_pkg::lpi_stat_t                         stat,
  input  wire logic                                  in_kind,
  input  wire logic signed [lpi_pkg::COORD_BITS-1:0] in_origin_x,
  input  wire logic signed [lpi_pkg::COORD_BITS-1:0] in_origin_y,
  input  wire logic signed [lpi_pkg::COORD_BITS-1:0] in_dest_x,
  input  wire logic signed [lpi_pkg::COORD_BITS-1:0] in_dest_y,
  input  wire logic        [lpi_pkg::TIME_BITS-1:0]  in_duration_ms,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed      [lpi_pkg::COORD_BITS-1:0] out_point_x,
  output logic signed      [lpi_pkg::COORD_BITS-1:0] out_point_y,
  output logic                                       out_active
);

  localparam int C = lpi_pkg::COORD_BITS;
  localparam int T = lpi_pkg::TIME_BITS;
  localparam int P = lpi_pkg::PROD_BITS;
  localparam int B = lpi_pkg::BASE_BITS;

  logic                 running_r;
  logic [T-1:0]         elapsed_r, span_r;
  logic signed [C-1:0]  from_x_r, from_y_r, to_x_r, to_y_r;
  logic                 neg_x_r, neg_y_r;
  logic [C-1:0]         mag_x_r, mag_y_r;
  logic [P-1:0]         quo_x_r, quo_y_r;
  logic [T-1:0]         rem_x_r, rem_y_r;
  logic                 out_valid_r, out_active_r;
  logic signed [C-1:0]  out_x_r, out_y_r;

  logic signed [lpi_pkg::DIFF_BITS-1:0] diff_x, diff_y;
  logic [T:0]           sh_x, sh_y;
  logic                 ge_x, ge_y;
  logic signed [C-1:0]  lerp_x, lerp_y;
  logic                 moving;

  function automatic logic signed [C-1:0] round_lerp(
    input logic signed [C-1:0] a,
    input logic                neg,
    input logic [C-1:0]        q,
    input logic [T-1:0]        r,
    input logic [T-1:0]        d
  );
    logic signed [B-1:0] ae, qe, base;
    logic [T-1:0]        rr;
    logic [T:0]          twice;
    logic                up;
    ae    = B'(a);
    qe    = B'({1'b0, q});
    base  = neg ? (ae - qe - B'(1)) : (ae + qe);
    rr    = neg ? (d - r) : r;
    twice = {rr, 1'b0};
    up    = base[B-1] ? (twice > {1'b0, d}) : (twice >= {1'b0, d});
    if (r == '0) begin
      round_lerp = neg ? C'(ae - qe) : C'(ae + qe);
    end else begin
      round_lerp = C'(base + B'(up));
    end
  endfunction

  assign diff_x = lpi_pkg::DIFF_BITS'(to_x_r) - lpi_pkg::DIFF_BITS'(from_x_r);
  assign diff_y = lpi_pkg::DIFF_BITS'(to_y_r) - lpi_pkg::DIFF_BITS'(from_y_r);

  assign sh_x = {rem_x_r, quo_x_r[P-1]};
  assign sh_y = {rem_y_r, quo_y_r[P-1]};
  assign ge_x = (sh_x >= {1'b0, span_r});
  assign ge_y = (sh_y >= {1'b0, span_r});

  assign lerp_x = round_lerp(from_x_r, neg_x_r, quo_x_r[C-1:0], rem_x_r, span_r);
  assign lerp_y = round_lerp(from_y_r, neg_y_r, quo_y_r[C-1:0], rem_y_r, span_r);
  assign moving = running_r && (elapsed_r < span_r);

  // motion state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      elapsed_r <= '0;
      span_r    <= '0;
      from_x_r  <= '0;
      from_y_r  <= '0;
      to_x_r    <= '0;
      to_y_r    <= '0;
    end else if (cmd.accept) begin
      if (in_kind == lpi_pkg::KIND_START) begin
        running_r <= 1'b1;
        elapsed_r <= '0;
        span_r    <= in_duration_ms;
        from_x_r  <= in_origin_x;
        from_y_r  <= in_origin_y;
        to_x_r    <= in_dest_x;
        to_y_r    <= in_dest_y;
      end else if (elapsed_r < span_r) begin
        elapsed_r <= elapsed_r + 1'b1;
      end
    end
  end

  // difference, product and serial divide
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      neg_x_r <= diff_x[C];
      neg_y_r <= diff_y[C];
      mag_x_r <= diff_x[C] ? C'(-diff_x) : C'(diff_x);
      mag_y_r <= diff_y[C] ? C'(-diff_y) : C'(diff_y);
    end
    if (cmd.mul) begin
      quo_x_r <= P'(mag_x_r) * P'(elapsed_r);
      quo_y_r <= P'(mag_y_r) * P'(elapsed_r);
      rem_x_r <= '0;
      rem_y_r <= '0;
    end else if (cmd.step) begin
      quo_x_r <= {quo_x_r[P-2:0], ge_x};
      quo_y_r <= {quo_y_r[P-2:0], ge_y};
      rem_x_r <= ge_x ? T'(sh_x - {1'b0, span_r}) : T'(sh_x);
      rem_y_r <= ge_y ? T'(sh_y - {1'b0, span_r}) : T'(sh_y);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_active_r <= moving;
      if (!running_r) begin
        out_x_r <= '0;
        out_y_r <= '0;
      end else if (!moving) begin
        out_x_r <= to_x_r;
        out_y_r <= to_y_r;
      end else begin
        out_x_r <= lerp_x;
        out_y_r <= lerp_y;
      end
    end
  end

  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_point_x   = out_x_r;
  assign out_point_y   = out_y_r;
  assign out_active    = out_active_r;

  a_elapsed_le_span: assert property (@(posedge clk) disable iff (!rst_n)
    elapsed_r <= span_r)
    else $error("elapsed beyond span");
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (span_r == '0 && elapsed_r == '0 && to_x_r == '0 && to_y_r == '0))
    else $error("state changed before start");
  a_active_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_active_r) |-> running_r)
    else $error("active without motion");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && span_r != '0) |=> (rem_x_r < span_r && rem_y_r < span_r))
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

### rtl/linear_point_interpolator_top.sv
// linear_point_interpolator_top: joins lpi_ctrl and lpi_dp
// depends on lpi_pkg, lpi_ctrl, lpi_dp
//
//   channel  handshake          payload
//   in       in_valid/in_stall  kind, origin_x/y, dest_x/y, duration_ms
//   out      out_valid/out_stall point_x, point_y, active
//
// each request runs load, difference, multiply, then a bit-serial restoring
// divide of the product by the duration, one bit a cycle, round and hand off
// reset: synchronous active-low, clears motion state, controller and out_valid
// a result waits in the output register; a stalled output holds the next
// request at the final step until the register frees up
`default_nettype none

module linear_point_interpolator_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_kind,
  input  wire logic signed [lpi_pkg::COORD_BITS-1:0] in_origin_x,
  input  wire logic signed [lpi_pkg::COORD_BITS-1:0] in_origin_y,
  input  wire logic signed [lpi_pkg::COORD_BITS-1:0] in_dest_x,
  input  wire logic signed [lpi_pkg::COORD_BITS-1:0] in_dest_y,
  input  wire logic        [lpi_pkg::TIME_BITS-1:0]  in_duration_ms,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed      [lpi_pkg::COORD_BITS-1:0] out_point_x,
  output logic signed      [lpi_pkg::COORD_BITS-1:0] out_point_y,
  output logic                                       out_active
);

  lpi_pkg::lpi_cmd_t  cmd;
  lpi_pkg::lpi_stat_t stat;

  lpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpi_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_kind),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_dest_x      (in_dest_x),
    .in_dest_y      (in_dest_y),
    .in_duration_ms (in_duration_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_active     (out_active)
  );

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for linear_point_interpolator_top; a directed table of requests,
// then random motions; points checked against typed values or an in-bench tween model
// depends on lpi_pkg and the linear_point_interpolator_top rtl
module tb;

  localparam int  IDLE_PCT    = 18;
  localparam int  RAND_ITEMS  = 950;
  localparam int  STUCK_LIMIT = 4000;
  localparam int  TAIL_CYCLES = 80;
  localparam int  PAUSE_AT    = 400;
  localparam int  QUIET_FROM  = 550;
  localparam int  QUIET_TO    = 700;
  localparam bit  TYPED       = 1'b1;
  localparam bit  PREDICTED   = 1'b0;

  typedef struct packed {
    logic                           kind;
    logic [lpi_pkg::COORD_BITS-1:0] ox;
    logic [lpi_pkg::COORD_BITS-1:0] oy;
    logic [lpi_pkg::COORD_BITS-1:0] dx;
    logic [lpi_pkg::COORD_BITS-1:0] dy;
    logic [lpi_pkg::TIME_BITS-1:0]  dur;
  } tween_req_t;

  typedef struct packed {
    logic [lpi_pkg::COORD_BITS-1:0] px;
    logic [lpi_pkg::COORD_BITS-1:0] py;
    logic                           act;
  } tween_pt_t;

  typedef struct {
    tween_req_t req;
    bit         typed;
    tween_pt_t  pt;
  } tween_row_t;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_stall;
  logic                                  in_kind;
  logic signed [lpi_pkg::COORD_BITS-1:0] in_origin_x;
  logic signed [lpi_pkg::COORD_BITS-1:0] in_origin_y;
  logic signed [lpi_pkg::COORD_BITS-1:0] in_dest_x;
  logic signed [lpi_pkg::COORD_BITS-1:0] in_dest_y;
  logic        [lpi_pkg::TIME_BITS-1:0]  in_duration_ms;
  logic                                  out_valid;
  logic                                  out_stall;
  logic signed [lpi_pkg::COORD_BITS-1:0] out_point_x;
  logic signed [lpi_pkg::COORD_BITS-1:0] out_point_y;
  logic                                  out_active;

  bit                                    mot_running;
  logic        [lpi_pkg::TIME_BITS-1:0]  mot_elapsed;
  logic        [lpi_pkg::TIME_BITS-1:0]  mot_span;
  logic signed [lpi_pkg::COORD_BITS-1:0] mot_from_x;
  logic signed [lpi_pkg::COORD_BITS-1:0] mot_from_y;
  logic signed [lpi_pkg::COORD_BITS-1:0] mot_to_x;
  logic signed [lpi_pkg::COORD_BITS-1:0] mot_to_y;

  tween_pt_t  point_q[$];
  tween_row_t dir_rows[$];
  tween_pt_t  want_pt;
  tween_pt_t  got_pt;
  int         mismatches;
  int         reqs_sent;
  bit         quiet;

  linear_point_interpolator_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_dest_x      (in_dest_x),
    .in_dest_y      (in_dest_y),
    .in_duration_ms (in_duration_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_active     (out_active)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // a + (b - a) * e / d rounded half away from zero, with 0 <= e < d
  function automatic logic [lpi_pkg::COORD_BITS-1:0] tween_coord(
    longint a, longint b, longint e, longint d);
    longint diff;
    longint mag;
    longint prod;
    longint q;
    longint r;
    longint base;
    longint frac;
    diff = b - a;
    mag  = (diff < 0) ? -diff : diff;
    prod = mag * e;
    q    = prod / d;
    r    = prod % d;
    if (diff >= 0) begin
      base = a + q;
      frac = r;
    end else if (r == 0) begin
      base = a - q;
      frac = 0;
    end else begin
      base = a - q - 1;
      frac = d - r;
    end
    if (frac != 0) begin
      if (base >= 0) begin
        if (2 * frac >= d) base = base + 1;
      end else if (2 * frac > d) begin
        base = base + 1;
      end
    end
    return base[lpi_pkg::COORD_BITS-1:0];
  endfunction

  task automatic advance_motion(input tween_req_t r, output tween_pt_t pt);
    if (r.kind == lpi_pkg::KIND_START) begin
      mot_running = 1'b1;
      mot_from_x  = r.ox;
      mot_from_y  = r.oy;
      mot_to_x    = r.dx;
      mot_to_y    = r.dy;
      mot_span    = r.dur;
      mot_elapsed = '0;
    end else if (mot_elapsed < mot_span) begin
      mot_elapsed = mot_elapsed + 1'b1;
    end
    if (!mot_running) begin
      pt = '0;
    end else if (mot_elapsed >= mot_span) begin
      pt = '{mot_to_x, mot_to_y, 1'b0};
    end else begin
      pt.px  = tween_coord(longint'(mot_from_x), longint'(mot_to_x),
                           longint'(mot_elapsed), longint'(mot_span));
      pt.py  = tween_coord(longint'(mot_from_y), longint'(mot_to_y),
                           longint'(mot_elapsed), longint'(mot_span));
      pt.act = 1'b1;
    end
  endtask

  task automatic add_row(input logic kind, input int ox, input int oy, input int dx,
                         input int dy, input int dur, input bit typed, input int px,
                         input int py, input logic act);
    tween_row_t row;
    row.req.kind = kind;
    row.req.ox   = ox[lpi_pkg::COORD_BITS-1:0];
    row.req.oy   = oy[lpi_pkg::COORD_BITS-1:0];
    row.req.dx   = dx[lpi_pkg::COORD_BITS-1:0];
    row.req.dy   = dy[lpi_pkg::COORD_BITS-1:0];
    row.req.dur  = dur[lpi_pkg::TIME_BITS-1:0];
    row.typed    = typed;
    row.pt.px    = px[lpi_pkg::COORD_BITS-1:0];
    row.pt.py    = py[lpi_pkg::COORD_BITS-1:0];
    row.pt.act   = act;
    dir_rows.push_back(row);
  endtask

  task automatic send_req(input tween_req_t r, input bit typed, input tween_pt_t pt);
    tween_pt_t model_pt;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= r.kind;
    in_origin_x    <= r.ox;
    in_origin_y    <= r.oy;
    in_dest_x      <= r.dx;
    in_dest_y      <= r.dy;
    in_duration_ms <= r.dur;
    do @(posedge clk); while (in_stall);
    advance_motion(r, model_pt);
    point_q.push_back(typed ? pt : model_pt);
    reqs_sent++;
  endtask

  function automatic logic [lpi_pkg::COORD_BITS-1:0] rand_coord();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(lpi_pkg::COORD_BITS-1){1'b0}}};
        1: return {1'b0, {(lpi_pkg::COORD_BITS-1){1'b1}}};
        2: return '0;
        default: return '1;
      endcase
    end else if (sel < 30) begin
      v = $urandom_range(0, 64) - 32;
      return v[lpi_pkg::COORD_BITS-1:0];
    end
    return lpi_pkg::COORD_BITS'($urandom);
  endfunction

  function automatic logic [lpi_pkg::TIME_BITS-1:0] rand_dur();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return '0;
    if (sel < 60) return lpi_pkg::TIME_BITS'($urandom_range(1, 12));
    if (sel < 75) return lpi_pkg::TIME_BITS'($urandom_range(13, 300));
    if (sel < 85) return lpi_pkg::TIME_BITS'(1);
    if (sel < 92) return '1;
    return lpi_pkg::TIME_BITS'($urandom);
  endfunction

  function automatic tween_req_t rand_fields(input logic kind);
    tween_req_t r;
    r.kind = kind;
    r.ox   = lpi_pkg::COORD_BITS'($urandom);
    r.oy   = lpi_pkg::COORD_BITS'($urandom);
    r.dx   = lpi_pkg::COORD_BITS'($urandom);
    r.dy   = lpi_pkg::COORD_BITS'($urandom);
    r.dur  = lpi_pkg::TIME_BITS'($urandom);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_pt = '{out_point_x, out_point_y, out_active};
        if (point_q.size() == 0) begin
          $display("%0t: point with no request pending, got x=%0d y=%0d active=%0b",
                   $time, $signed(got_pt.px), $signed(got_pt.py), got_pt.act);
          mismatches++;
        end else begin
          want_pt = point_q.pop_front();
          if (want_pt != got_pt) begin
            $display("%0t: mismatch, want x=%0d y=%0d act=%0b, got x=%0d y=%0d act=%0b",
                     $time, $signed(want_pt.px), $signed(want_pt.py), want_pt.act,
                     $signed(got_pt.px), $signed(got_pt.py), got_pt.act);
            mismatches++;
          end
        end
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("%0t: timeout, nothing moved for %0d cycles", $time, STUCK_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    tween_req_t r;
    int         n_ticks;
    bit         paused;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = lpi_pkg::KIND_START;
    in_origin_x    = '0;
    in_origin_y    = '0;
    in_dest_x      = '0;
    in_dest_y      = '0;
    in_duration_ms = '0;
    quiet          = 1'b0;
    paused         = 1'b0;
    mismatches     = 0;
    reqs_sent      = 0;
    mot_running    = 1'b0;
    mot_elapsed    = '0;
    mot_span       = '0;
    mot_from_x     = '0;
    mot_from_y     = '0;
    mot_to_x       = '0;
    mot_to_y       = '0;

    // idle after reset, ticks change nothing
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, TYPED, 0, 0, 1'b0);
    add_row(lpi_pkg::KIND_TICK, -1, -1, -1, -1, 65535, TYPED, 0, 0, 1'b0);
    // zero duration jumps to destination
    add_row(lpi_pkg::KIND_START, -32768, 32767, 32767, -32768, 0, TYPED, 32767, -32768, 1'b0);
    add_row(lpi_pkg::KIND_TICK, 123, -45, 6, 7, 8, TYPED, 32767, -32768, 1'b0);
    // short motion, runs out and saturates
    add_row(lpi_pkg::KIND_START, 0, 0, 10, -10, 4, TYPED, 0, 0, 1'b1);
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, PREDICTED, 0, 0, 1'b0);
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, PREDICTED, 0, 0, 1'b0);
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, PREDICTED, 0, 0, 1'b0);
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, TYPED, 10, -10, 1'b0);
    add_row(lpi_pkg::KIND_TICK, -7, 9, 1, 2, 3, TYPED, 10, -10, 1'b0);
    // half-way ties on both signs
    add_row(lpi_pkg::KIND_START, 0, 0, 1, -1, 2, TYPED, 0, 0, 1'b1);
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, PREDICTED, 0, 0, 1'b0);
    add_row(lpi_pkg::KIND_START, -3, 3, -2, 2, 2, TYPED, -3, 3, 1'b1);
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, PREDICTED, 0, 0, 1'b0);
    // full-range sweep over the longest duration
    add_row(lpi_pkg::KIND_START, -32768, -32768, 32767, 32767, 65535, TYPED,
            -32768, -32768, 1'b1);
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, PREDICTED, 0, 0, 1'b0);
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, PREDICTED, 0, 0, 1'b0);
    // restart in the middle of a motion
    add_row(lpi_pkg::KIND_START, 32767, -32768, -32768, 32767, 3, TYPED,
            32767, -32768, 1'b1);
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, PREDICTED, 0, 0, 1'b0);
    add_row(lpi_pkg::KIND_START, 5, 7, 100, -100, 1, TYPED, 5, 7, 1'b1);
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, TYPED, 100, -100, 1'b0);
    add_row(lpi_pkg::KIND_START, 100, 200, -300, 400, 3, TYPED, 100, 200, 1'b1);
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, PREDICTED, 0, 0, 1'b0);
    add_row(lpi_pkg::KIND_TICK, 0, 0, 0, 0, 0, PREDICTED, 0, 0, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].pt);

    reqs_sent = 0;
    while (reqs_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 99) < 10) begin
        send_req(rand_fields(1'($urandom_range(0, 1))), PREDICTED, '0);
      end else begin
        r      = rand_fields(lpi_pkg::KIND_START);
        r.ox   = rand_coord();
        r.oy   = rand_coord();
        r.dx   = rand_coord();
        r.dy   = rand_coord();
        r.dur  = rand_dur();
        send_req(r, PREDICTED, '0);
        n_ticks = $urandom_range(0, (r.dur > 37) ? 40 : int'(r.dur) + 3);
        repeat (n_ticks) send_req(rand_fields(lpi_pkg::KIND_TICK), PREDICTED, '0);
      end
      // drain the pipeline once with the sender held off
      if (!paused && reqs_sent >= PAUSE_AT) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        while (point_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      quiet = (reqs_sent >= QUIET_FROM) && (reqs_sent < QUIET_TO);
    end

    in_valid <= 1'b0;
    quiet = 1'b0;
    while (point_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && point_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
